[rtl/core/mfd_pkg.sv]
// Shared types and constants of the motor feedback decoder.
// No dependencies; mfd_ctrl, mfd_datapath and the top level import this package.
package mfd_pkg;

  // Fixed-point setup
  localparam int HALF_REVOLUTION = 4096;
  localparam int FRAC_BITS       = 16;

  // 2*pi in Q60; per-count angle step and rpm-to-rad/s step keep Q60
  localparam logic [63:0] TWO_PI_Q60 = 64'h6487_ED51_10B4_611A;
  localparam logic [63:0] ANGLE_K    = TWO_PI_Q60 / 64'(2 * HALF_REVOLUTION);
  localparam logic [63:0] SPEED_K    = TWO_PI_Q60 / 64'd60;

  localparam logic [5:0] SHIFT_K   = 6'(60 - FRAC_BITS);
  localparam logic [5:0] SHIFT_Q16 = 6'd16;
  localparam logic [5:0] SHIFT_CUR = 6'(24 - FRAC_BITS);

  localparam logic signed [63:0] TURN_COUNTS = 64'(2 * HALF_REVOLUTION);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_GEAR_RATIO = 3'd0,
    REG_TORQUE_GAIN    = 3'd1,
    REG_SPEED_ALPHA    = 3'd2,
    REG_CURRENT_ALPHA  = 3'd3,
    REG_CURRENT_SCALE  = 3'd4
  } mfd_reg_t;

  // Products run on the shared mul/shift unit, in issue order
  typedef enum logic [3:0] {
    OP_ASGL1 = 4'd0,   // enc * angle step
    OP_ASGL2 = 4'd1,   // * inverse ratio -> single-turn angle
    OP_AMUL1 = 4'd2,   // position * angle step
    OP_AMUL2 = 4'd3,   // * inverse ratio -> multi-turn angle
    OP_SPD1  = 4'd4,   // rpm * speed step
    OP_SPD2  = 4'd5,   // * inverse ratio -> raw speed
    OP_SEMA1 = 4'd6,   // alpha * (raw - est)
    OP_SEMA2 = 4'd7,   // round((est << 16) + prod) -> speed estimate
    OP_CUR   = 4'd8,   // current count * scale
    OP_CEMA1 = 4'd9,
    OP_CEMA2 = 4'd10,
    OP_TRQ   = 4'd11   // current estimate * torque gain
  } mfd_op_t;

  localparam mfd_op_t OP_LAST = OP_TRQ;

  typedef struct packed {
    logic [63:0] frame_data;
    logic [63:0] timestamp_us;
  } mfd_in_t;

  typedef struct packed {
    logic        [15:0] encoder_count;
    logic signed [15:0] speed_rpm;
    logic signed [15:0] current_count;
    logic signed [7:0]  temperature_c;
    logic        [7:0]  fault_code;
    logic signed [31:0] turns;
    logic        [23:0] angle_single;
    logic signed [47:0] angle_multi;
    logic signed [31:0] speed_filtered;
    logic signed [31:0] current_filtered;
    logic signed [31:0] torque;
    logic        [31:0] interval_us;
  } mfd_out_t;

  // Controller -> datapath
  typedef struct packed {
    logic    load;
    logic    prep;
    logic    start;
    logic    store;
    logic    emit;
    mfd_op_t op;
  } mfd_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic done;
    logic out_free;
  } mfd_sts_t;

endpackage

[rtl/core/mfd_mulsh.sv]
// Multi-cycle multiply, signed a_in by unsigned b_in, rounding right shift, 64-bit saturation.
// One 32x32 partial product per cycle into a 128-bit accumulator. No package use.
module mfd_mulsh (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a_in,
  input  logic [63:0] b_in,
  input  logic [5:0]  sh_in,
  output logic        done,
  output logic [63:0] res
);

  typedef enum logic [1:0] {P_IDLE, P_MUL, P_RND, P_OUT} phase_t;

  phase_t       phase;
  logic         neg;
  logic [63:0]  am;
  logic [63:0]  bm;
  logic [5:0]   sh;
  logic [127:0] acc;
  logic [1:0]   idx;

  logic [3:0]   need;
  logic [1:0]   nxt;
  logic         nxt_ok;
  logic [31:0]  a_half;
  logic [31:0]  b_half;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [127:0] rnd;
  logic [127:0] shifted;
  logic [63:0]  mag;

  // pp order: lo*lo, lo*bhi, ahi*lo, ahi*bhi; zero halves are skipped
  assign need = {(|am[63:32]) && (|bm[63:32]), |am[63:32], |bm[63:32], 1'b1};

  always_comb begin
    nxt    = idx;
    nxt_ok = 1'b0;
    for (int j = 3; j >= 1; j--) begin
      if (j > int'(idx) && need[j]) begin
        nxt    = 2'(j);
        nxt_ok = 1'b1;
      end
    end
  end

  assign a_half = idx[1] ? am[63:32] : am[31:0];
  assign b_half = idx[0] ? bm[63:32] : bm[31:0];
  assign pp     = a_half * b_half;

  always_comb begin
    case (idx)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  assign rnd     = (sh == 6'd0) ? 128'd0 : (128'd1 << (sh - 6'd1));
  assign shifted = acc >> sh;
  assign mag     = ((|shifted[127:64]) || shifted[63]) ? 64'h7FFF_FFFF_FFFF_FFFF
                                                       : shifted[63:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        P_IDLE: begin
          if (start) begin
            neg   <= a_in[63];
            am    <= a_in[63] ? (~a_in + 64'd1) : a_in;
            bm    <= b_in;
            sh    <= sh_in;
            acc   <= '0;
            idx   <= 2'd0;
            phase <= P_MUL;
          end
        end
        P_MUL: begin
          acc <= acc + pp_sh;
          idx <= nxt;
          if (!nxt_ok) begin
            phase <= P_RND;
          end
        end
        P_RND: begin
          acc   <= acc + rnd;
          phase <= P_OUT;
        end
        P_OUT: begin
          res   <= neg ? (~mag + 64'd1) : mag;
          done  <= 1'b1;
          phase <= P_IDLE;
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/mfd_ctrl.sv]
// Sequencer of the decoder: accepts a frame, steps the datapath through the
// product list and hands the result to the output register. Uses mfd_pkg.
module mfd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mfd_pkg::mfd_sts_t sts,
  output mfd_pkg::mfd_cmd_t cmd
);

  import mfd_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_ISSUE, S_WAIT, S_EMIT} state_t;

  state_t  state;
  mfd_op_t op;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.load  = in_valid && (state == S_IDLE);
    cmd.prep  = (state == S_PREP);
    cmd.start = (state == S_ISSUE);
    cmd.store = (state == S_WAIT) && sts.done;
    cmd.emit  = (state == S_EMIT) && sts.out_free;
    cmd.op    = op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_ASGL1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          op    <= OP_ASGL1;
          state <= S_ISSUE;
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (sts.done) begin
            if (op == OP_LAST) begin
              state <= S_EMIT;
            end else begin
              op    <= mfd_op_t'(op + 4'd1);
              state <= S_ISSUE;
            end
          end
        end
        S_EMIT: begin
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/mfd_datapath.sv]
// Datapath: frame unpack, turn unwrap, config registers, filter state,
// operand select for the mul/shift unit and the output register.
// Uses mfd_pkg and instantiates mfd_mulsh.
module mfd_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  mfd_pkg::mfd_cmd_t               cmd,
  output mfd_pkg::mfd_sts_t               sts,
  input  mfd_pkg::mfd_in_t                in_item,
  input  logic                            cfg_we,
  input  logic [mfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mfd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mfd_pkg::mfd_out_t               out_item
);

  import mfd_pkg::*;

  localparam logic signed [17:0] HALF_POS = 18'(HALF_REVOLUTION);
  localparam logic signed [17:0] HALF_NEG = -HALF_POS;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    if (!v[63] && (|v[62:31])) begin
      return 32'h7FFF_FFFF;
    end else if (v[63] && !(&v[62:31])) begin
      return 32'h8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic [47:0] sat48(input logic [63:0] v);
    if (!v[63] && (|v[62:47])) begin
      return 48'h7FFF_FFFF_FFFF;
    end else if (v[63] && !(&v[62:47])) begin
      return 48'h8000_0000_0000;
    end else begin
      return v[47:0];
    end
  endfunction

  function automatic logic [16:0] clamp_alpha(input logic [16:0] a);
    return (a[16] && (|a[15:0])) ? 17'h1_0000 : a;
  endfunction

  // Config
  logic [23:0] inverse_gear_ratio;
  logic [23:0] torque_gain;
  logic [16:0] speed_alpha;
  logic [16:0] current_alpha;
  logic [23:0] current_scale;

  // Persistent state
  logic [15:0] prev_enc;
  logic [31:0] turns;
  logic [31:0] spd_est;
  logic [31:0] cur_est;
  logic [63:0] prev_ts;

  // Per-frame working registers
  logic [15:0]        enc;
  logic [15:0]        rpm;
  logic [15:0]        cur;
  logic [7:0]         temp;
  logic [7:0]         fault;
  logic [31:0]        dt;
  logic signed [63:0] pos;
  logic [63:0]        t;
  logic [23:0]        a_single;
  logic [47:0]        a_multi;
  logic [31:0]        trq;

  logic [15:0]        enc_in;
  logic signed [17:0] enc_diff;
  logic [63:0]        ts_diff;
  logic [63:0]        op_a;
  logic [63:0]        op_b;
  logic [5:0]         op_sh;
  logic               mul_done;
  logic [63:0]        mul_res;
  logic [31:0]        res_sat;

  assign enc_in   = in_item.frame_data[63:48];
  assign enc_diff = $signed({2'b00, enc_in}) - $signed({2'b00, prev_enc});
  assign ts_diff  = in_item.timestamp_us - prev_ts;
  assign res_sat  = sat32(mul_res);

  always_comb begin
    op_a  = '0;
    op_b  = '0;
    op_sh = SHIFT_Q16;
    unique case (cmd.op) inside
      OP_ASGL1: begin
        op_a  = {48'd0, enc};
        op_b  = ANGLE_K;
        op_sh = SHIFT_K;
      end
      OP_AMUL1: begin
        op_a  = pos;
        op_b  = ANGLE_K;
        op_sh = SHIFT_K;
      end
      OP_SPD1: begin
        op_a  = {{48{rpm[15]}}, rpm};
        op_b  = SPEED_K;
        op_sh = SHIFT_K;
      end
      OP_ASGL2, OP_AMUL2, OP_SPD2: begin
        op_a = t;
        op_b = {40'd0, inverse_gear_ratio};
      end
      // filter written as est*65536 + alpha*(raw - est)
      OP_SEMA1: begin
        op_a  = t - {{32{spd_est[31]}}, spd_est};
        op_b  = {47'd0, clamp_alpha(speed_alpha)};
        op_sh = 6'd0;
      end
      OP_SEMA2: begin
        op_a = {{16{spd_est[31]}}, spd_est, 16'd0} + t;
        op_b = 64'd1;
      end
      OP_CUR: begin
        op_a  = {{48{cur[15]}}, cur};
        op_b  = {40'd0, current_scale};
        op_sh = SHIFT_CUR;
      end
      OP_CEMA1: begin
        op_a  = t - {{32{cur_est[31]}}, cur_est};
        op_b  = {47'd0, clamp_alpha(current_alpha)};
        op_sh = 6'd0;
      end
      OP_CEMA2: begin
        op_a = {{16{cur_est[31]}}, cur_est, 16'd0} + t;
        op_b = 64'd1;
      end
      OP_TRQ: begin
        op_a = {{32{cur_est[31]}}, cur_est};
        op_b = {40'd0, torque_gain};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  mfd_mulsh u_mulsh (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start),
    .a_in  (op_a),
    .b_in  (op_b),
    .sh_in (op_sh),
    .done  (mul_done),
    .res   (mul_res)
  );

  assign sts.done     = mul_done;
  assign sts.out_free = !out_valid || out_ready;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_gear_ratio <= 24'h01_0000;
      torque_gain        <= 24'h01_0000;
      speed_alpha        <= 17'h0_8000;
      current_alpha      <= 17'h0_8000;
      current_scale      <= 24'h00_0000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INV_GEAR_RATIO: inverse_gear_ratio <= cfg_data;
        REG_TORQUE_GAIN:    torque_gain        <= cfg_data;
        REG_SPEED_ALPHA:    speed_alpha        <= cfg_data[16:0];
        REG_CURRENT_ALPHA:  current_alpha      <= cfg_data[16:0];
        REG_CURRENT_SCALE:  current_scale      <= cfg_data;
        default: ;
      endcase
    end
  end

  // State carried from frame to frame
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_enc <= '0;
      turns    <= '0;
      spd_est  <= '0;
      cur_est  <= '0;
      prev_ts  <= '0;
    end else begin
      if (cmd.load) begin
        prev_enc <= enc_in;
        prev_ts  <= in_item.timestamp_us;
        // jump over half a revolution is a wrap
        if (enc_diff > HALF_POS) begin
          turns <= turns - 32'd1;
        end else if (enc_diff < HALF_NEG) begin
          turns <= turns + 32'd1;
        end
      end
      if (cmd.store && cmd.op == OP_SEMA2) begin
        spd_est <= sat32(mul_res);
      end
      if (cmd.store && cmd.op == OP_CEMA2) begin
        cur_est <= sat32(mul_res);
      end
    end
  end

  // Per-frame payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      enc   <= enc_in;
      rpm   <= in_item.frame_data[47:32];
      cur   <= in_item.frame_data[31:16];
      temp  <= in_item.frame_data[15:8];
      fault <= in_item.frame_data[7:0];
      dt    <= (|ts_diff[63:32]) ? 32'hFFFF_FFFF : ts_diff[31:0];
    end
    if (cmd.prep) begin
      pos <= $signed(turns) * TURN_COUNTS + $signed({48'd0, enc});
    end
    if (cmd.store) begin
      case (cmd.op) inside
        OP_ASGL2: begin
          a_single <= ($signed(mul_res) > 64'sd16777215) ? 24'hFF_FFFF : mul_res[23:0];
        end
        OP_AMUL2: a_multi <= sat48(mul_res);
        OP_TRQ:   trq     <= sat32(mul_res);
        // raw samples enter the filters saturated to 32 bits
        OP_SPD2, OP_CUR: t <= {{32{res_sat[31]}}, res_sat};
        default:  t <= mul_res;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item.encoder_count    <= enc;
      out_item.speed_rpm        <= rpm;
      out_item.current_count    <= cur;
      out_item.temperature_c    <= temp;
      out_item.fault_code       <= fault;
      out_item.turns            <= turns;
      out_item.angle_single     <= a_single;
      out_item.angle_multi      <= a_multi;
      out_item.speed_filtered   <= spd_est;
      out_item.current_filtered <= cur_est;
      out_item.torque           <= trq;
      out_item.interval_us      <= dt;
    end
  end

endmodule

[rtl/core/motor_feedback_decoder_core.sv]
// Top level of the motor feedback decoder.
// Uses mfd_pkg; instantiates mfd_ctrl and mfd_datapath.
//
// Decodes one 8-byte motor feedback frame per input beat into raw fields,
// a wrap-counted turn number, single- and multi-turn output angles, filtered
// speed and current, torque and the saturated frame interval; the angles,
// speed, current and torque are fixed point with FRAC_BITS fraction bits.
// The twelve scaling and filter products run one after another on a single
// 32x32 multiplier, one partial product per cycle (one to four per product,
// depending on the operand sizes), each followed by a round step, a saturate
// step and a handoff back to the sequencer. The next frame is accepted while
// the previous result still waits in the output register. Configuration
// writes are always taken (cfg_ready is tied high) and must only be issued
// while no frame is in flight.
module motor_feedback_decoder_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mfd_pkg::mfd_in_t                in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mfd_pkg::mfd_out_t               out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mfd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import mfd_pkg::*;

  mfd_cmd_t cmd;
  mfd_sts_t sts;
  logic     cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  mfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mfd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
